>>> sv/rgb_pair_to_ycbcr422_unit_macros.svh
// Assertion macros for the RGB pair to 4:2:2 converter checker.
// Every macro assumes a signal named clock and one named reset in the scope where it is used.
`ifndef RGB_PAIR_TO_YCBCR422_UNIT_MACROS_SVH
`define RGB_PAIR_TO_YCBCR422_UNIT_MACROS_SVH

// The consequent must hold in the same cycle. The check is off while reset is high.
`define RPYC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the next cycle. The check is off while reset is high.
`define RPYC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold in the next cycle. The check stays on during reset.
`define RPYC_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/rpyc_pkg.sv
// Package for the RGB pair to 4:2:2 converter: coefficients, offsets and shared types.
// It depends on nothing. The front, queue, back and top-level files use it.
`timescale 1ns / 1ps
`default_nettype none

package rpyc_pkg;

   localparam int TERM_WIDTH     = 24;
   localparam int FRACTION_WIDTH = 16;
   localparam int BYTE_WIDTH     = 8;

   localparam logic [TERM_WIDTH-1:0] LUMA_RED   = 24'd16829;
   localparam logic [TERM_WIDTH-1:0] LUMA_GREEN = 24'd33039;
   localparam logic [TERM_WIDTH-1:0] LUMA_BLUE  = 24'd6416;

   localparam logic [TERM_WIDTH-1:0] CB_HALF_BLUE  = 24'd14383;
   localparam logic [TERM_WIDTH-1:0] CB_HALF_RED   = 24'd4853;
   localparam logic [TERM_WIDTH-1:0] CB_HALF_GREEN = 24'd9530;
   localparam logic [TERM_WIDTH-1:0] CR_HALF_RED   = 24'd14386;
   localparam logic [TERM_WIDTH-1:0] CR_HALF_GREEN = 24'd12046;
   localparam logic [TERM_WIDTH-1:0] CR_HALF_BLUE  = 24'd2340;

   localparam logic [TERM_WIDTH-1:0] CB_QUARTER_BLUE  = 24'd7191;
   localparam logic [TERM_WIDTH-1:0] CB_QUARTER_RED   = 24'd2426;
   localparam logic [TERM_WIDTH-1:0] CB_QUARTER_GREEN = 24'd4765;
   localparam logic [TERM_WIDTH-1:0] CR_QUARTER_RED   = 24'd7193;
   localparam logic [TERM_WIDTH-1:0] CR_QUARTER_GREEN = 24'd6023;
   localparam logic [TERM_WIDTH-1:0] CR_QUARTER_BLUE  = 24'd1170;

   localparam logic [BYTE_WIDTH-1:0] CHROMA_OFFSET = 8'd128;
   localparam logic [BYTE_WIDTH-1:0] LUMA_OFFSET   = 8'd16;

   typedef struct packed {
      logic [TERM_WIDTH-1:0] luma_first_part;
      logic [TERM_WIDTH-1:0] luma_second_part;
      logic [TERM_WIDTH-1:0] cb_half;
      logic [TERM_WIDTH-1:0] cb_quarter;
      logic [TERM_WIDTH-1:0] cr_half;
      logic [TERM_WIDTH-1:0] cr_quarter;
   } term_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } queue_status_type;

endpackage

`default_nettype wire

>>> sv/rpyc_channels.sv
// Channel interfaces for the RGB pair to 4:2:2 converter: pixel pair in, 4:2:2 group out.
// The interfaces are self-contained and use no package.
`timescale 1ns / 1ps
`default_nettype none

interface rpyc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_red;
   logic [7:0] first_green;
   logic [7:0] first_blue;
   logic [7:0] second_red;
   logic [7:0] second_green;
   logic [7:0] second_blue;

   modport source (
      output valid, first_red, first_green, first_blue,
      output second_red, second_green, second_blue,
      input  ready
   );
   modport sink (
      input  valid, first_red, first_green, first_blue,
      input  second_red, second_green, second_blue,
      output ready
   );
endinterface

interface rpyc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cb_out;
   logic [7:0] luma_first;
   logic [7:0] cr_out;
   logic [7:0] luma_second;

   modport source (
      output valid, cb_out, luma_first, cr_out, luma_second,
      input  ready
   );
   modport sink (
      input  valid, cb_out, luma_first, cr_out, luma_second,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/rpyc_front.sv
// Front stage: accepts pixel pairs and forms the constant-coefficient luma and chroma terms.
// It depends on rpyc_pkg and rpyc_req_if.
`timescale 1ns / 1ps
`default_nettype none

module rpyc_front (
   rpyc_req_if.sink                  req_chan,
   input  rpyc_pkg::queue_status_type status,
   output logic                      push,
   output rpyc_pkg::term_type        term
);
   import rpyc_pkg::*;

   logic [TERM_WIDTH-1:0] r0;
   logic [TERM_WIDTH-1:0] g0;
   logic [TERM_WIDTH-1:0] b0;
   logic [TERM_WIDTH-1:0] r1;
   logic [TERM_WIDTH-1:0] g1;
   logic [TERM_WIDTH-1:0] b1;

   assign r0 = TERM_WIDTH'(req_chan.first_red);
   assign g0 = TERM_WIDTH'(req_chan.first_green);
   assign b0 = TERM_WIDTH'(req_chan.first_blue);
   assign r1 = TERM_WIDTH'(req_chan.second_red);
   assign g1 = TERM_WIDTH'(req_chan.second_green);
   assign b1 = TERM_WIDTH'(req_chan.second_blue);

   assign req_chan.ready = !status.full;
   assign push           = req_chan.valid && !status.full;

   // Chroma terms are kept modulo 2^24 since no higher bit reaches an output.
   always_comb begin
      term.luma_first_part  = LUMA_RED * r0 + LUMA_GREEN * g0 + LUMA_BLUE * b0;
      term.luma_second_part = LUMA_RED * r1 + LUMA_GREEN * g1 + LUMA_BLUE * b1;
      term.cb_half          = CB_HALF_BLUE * b0 - CB_HALF_RED * r0 - CB_HALF_GREEN * g0;
      term.cr_half          = CR_HALF_RED * r0 - CR_HALF_GREEN * g0 - CR_HALF_BLUE * b0;
      term.cb_quarter       = CB_QUARTER_BLUE * b1 - CB_QUARTER_RED * r1
                              - CB_QUARTER_GREEN * g1;
      term.cr_quarter       = CR_QUARTER_RED * r1 - CR_QUARTER_GREEN * g1
                              - CR_QUARTER_BLUE * b1;
   end

endmodule

`default_nettype wire

>>> sv/rpyc_queue.sv
// Short queue of computed terms between the front and back stages.
// It depends on rpyc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpyc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rpyc_pkg::term_type         term_in,
   input  logic                       pop,
   output rpyc_pkg::queue_status_type status,
   output rpyc_pkg::term_type         head
);
   import rpyc_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   term_type           entry_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff;
   logic [IDX_W-1:0]   wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff;
   logic [IDX_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= term_in;
      end
   end

   assign status.full       = (count_ff == CNT_W'(DEPTH));
   assign status.head_valid = (count_ff != '0);
   assign head              = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

>>> sv/rpyc_back.sv
// Back stage: adds the carried fractions and the previous chroma term, holds the result register.
// It depends on rpyc_pkg and rpyc_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module rpyc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rpyc_pkg::queue_status_type status,
   input  rpyc_pkg::term_type         head,
   output logic                       pop,
   rpyc_rsp_if.source                 rsp_chan
);
   import rpyc_pkg::*;

   logic [FRACTION_WIDTH-1:0] luma_frac_ff;
   logic [FRACTION_WIDTH-1:0] luma_frac_in;
   logic [FRACTION_WIDTH-1:0] cb_frac_ff;
   logic [FRACTION_WIDTH-1:0] cb_frac_in;
   logic [FRACTION_WIDTH-1:0] cr_frac_ff;
   logic [FRACTION_WIDTH-1:0] cr_frac_in;
   logic [TERM_WIDTH-1:0]     cb_prev_ff;
   logic [TERM_WIDTH-1:0]     cb_prev_in;
   logic [TERM_WIDTH-1:0]     cr_prev_ff;
   logic [TERM_WIDTH-1:0]     cr_prev_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [BYTE_WIDTH-1:0]     cb_out_ff;
   logic [BYTE_WIDTH-1:0]     luma_first_ff;
   logic [BYTE_WIDTH-1:0]     cr_out_ff;
   logic [BYTE_WIDTH-1:0]     luma_second_ff;

   logic [TERM_WIDTH-1:0]     y0;
   logic [TERM_WIDTH-1:0]     y1;
   logic [TERM_WIDTH-1:0]     cb_sum;
   logic [TERM_WIDTH-1:0]     cr_sum;

   assign pop = status.head_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      y0     = head.luma_first_part + TERM_WIDTH'(luma_frac_ff);
      y1     = head.luma_second_part + TERM_WIDTH'(y0[FRACTION_WIDTH-1:0]);
      cb_sum = cb_prev_ff + head.cb_half + head.cb_quarter + TERM_WIDTH'(cb_frac_ff);
      cr_sum = cr_prev_ff + head.cr_half + head.cr_quarter + TERM_WIDTH'(cr_frac_ff);

      luma_frac_in = luma_frac_ff;
      cb_frac_in   = cb_frac_ff;
      cr_frac_in   = cr_frac_ff;
      cb_prev_in   = cb_prev_ff;
      cr_prev_in   = cr_prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (pop) begin
         luma_frac_in = y1[FRACTION_WIDTH-1:0];
         cb_frac_in   = cb_sum[FRACTION_WIDTH-1:0];
         cr_frac_in   = cr_sum[FRACTION_WIDTH-1:0];
         cb_prev_in   = head.cb_quarter;
         cr_prev_in   = head.cr_quarter;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_frac_ff <= '0;
         cb_frac_ff   <= '0;
         cr_frac_ff   <= '0;
         cb_prev_ff   <= '0;
         cr_prev_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         luma_frac_ff <= luma_frac_in;
         cb_frac_ff   <= cb_frac_in;
         cr_frac_ff   <= cr_frac_in;
         cb_prev_ff   <= cb_prev_in;
         cr_prev_ff   <= cr_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cb_out_ff      <= cb_sum[TERM_WIDTH-1:FRACTION_WIDTH] + CHROMA_OFFSET;
         luma_first_ff  <= y0[TERM_WIDTH-1:FRACTION_WIDTH] + LUMA_OFFSET;
         cr_out_ff      <= cr_sum[TERM_WIDTH-1:FRACTION_WIDTH] + CHROMA_OFFSET;
         luma_second_ff <= y1[TERM_WIDTH-1:FRACTION_WIDTH] + LUMA_OFFSET;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cb_out      = cb_out_ff;
   assign rsp_chan.luma_first  = luma_first_ff;
   assign rsp_chan.cr_out      = cr_out_ff;
   assign rsp_chan.luma_second = luma_second_ff;

endmodule

`default_nettype wire

>>> sv/rgb_pair_to_ycbcr422_unit.sv
// An accepted transaction is registered first in the queue and then in the result register.
// Throughput: one pixel pair per clock, as long as the result side keeps taking transactions.
// The back stage's carry adds for the luma and chroma fractions set that rate.
// The queue holds QUEUE_DEPTH transactions and the result register holds one more.
// Synchronous reset clears the carried fractions, the chroma terms, the queue and the result valid.
`timescale 1ns / 1ps
`default_nettype none

module rgb_pair_to_ycbcr422_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   rpyc_req_if.sink   req_chan,
   rpyc_rsp_if.source rsp_chan
);
   import rpyc_pkg::*;

   queue_status_type status;
   term_type         front_term;
   term_type         head_term;
   logic             push;
   logic             pop;

   rpyc_front u_front (
      .req_chan (req_chan),
      .status   (status),
      .push     (push),
      .term     (front_term)
   );

   rpyc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .term_in (front_term),
      .pop     (pop),
      .status  (status),
      .head    (head_term)
   );

   rpyc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .head     (head_term),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

>>> sv/rpyc_checker.sv
// Port-level checker for the RGB pair to 4:2:2 converter, bound to the top level.
// It depends on rgb_pair_to_ycbcr422_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_pair_to_ycbcr422_unit_macros.svh"

module rpyc_checker #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_cb_out,
   input logic [7:0] rsp_luma_first,
   input logic [7:0] rsp_cr_out,
   input logic [7:0] rsp_luma_second
);
   localparam int PEND_W = $clog2(QUEUE_DEPTH + 2);

   logic [PEND_W-1:0] pending_ff;
   logic [PEND_W-1:0] pending_in;
   logic [31:0]       rsp_payload;
   logic              in_taken;
   logic              out_taken;

   assign in_taken    = req_valid && req_ready;
   assign out_taken   = rsp_valid && rsp_ready;
   assign rsp_payload = {rsp_cb_out, rsp_luma_first, rsp_cr_out, rsp_luma_second};

   always_comb begin
      pending_in = pending_ff;
      if (in_taken && !out_taken) begin
         pending_in = pending_ff + 1'b1;
      end else if (out_taken && !in_taken) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A result is never shown without an accepted transaction that it belongs to.
   `RPYC_ASSERT_IMPL(a_no_orphan_result, rsp_valid, pending_ff != '0, "result without transaction")
   // The block never holds more transactions than the queue and the result register.
   `RPYC_ASSERT_IMPL(a_capacity, 1'b1, pending_ff <= PEND_W'(QUEUE_DEPTH + 1), "too many pending")
   // An empty block always takes a new transaction.
   `RPYC_ASSERT_IMPL(a_idle_ready, pending_ff == '0, req_ready, "idle block refuses input")
   // A stalled result stays on the port unchanged.
   `RPYC_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result changed while stalled")
   // Reset leaves no result on the port.
   `RPYC_ASSERT_NEXT_ALWAYS(a_reset_clear, reset, !rsp_valid, "result valid after reset")

endmodule

bind rgb_pair_to_ycbcr422_unit rpyc_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rpyc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_cb_out      (rsp_chan.cb_out),
   .rsp_luma_first  (rsp_chan.luma_first),
   .rsp_cr_out      (rsp_chan.cr_out),
   .rsp_luma_second (rsp_chan.luma_second)
);

`default_nettype wire
